@@ hw/rtl/mlem_pkg.sv @@
// mlem_pkg: shared types, codes and helpers for the MLEM projection update block.
// Depends on nothing; every other file in hw/rtl imports it.
package mlem_pkg;

    // input item kinds
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_LINE   = 2'd1;
    localparam logic [1:0] KIND_UPDATE = 2'd2;

    // blend modes; the two unused codes fall back to no blending
    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_MUL   = 3'd1;
    localparam logic [2:0] MODE_MIX   = 3'd2;
    localparam logic [2:0] MODE_FORCE = 3'd3;
    localparam logic [2:0] MODE_INV   = 3'd4;
    localparam logic [2:0] MODE_BEAM  = 3'd5;

    // configuration register indexes
    localparam int         CFG_IDX_W      = 1;
    localparam int         CFG_DATA_W     = 17;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_MU   = 1'b1;

    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [31:0] MAX32   = 32'hFFFF_FFFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] voxel_index;
        logic [31:0] sample_value;
        logic [31:0] beam_value;
        logic        line_last;
    } mlem_in_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic        is_projection;
        logic        line_skipped;
        logic        saturated;
    } mlem_out_t;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_LINE,
        OP_UPDATE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [11:0] voxel_index;
        logic        in_range;
        logic [31:0] sample_value;
        logic [31:0] beam_value;
        logic        line_last;
    } mlem_cmd_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [16:0] mu;
        logic [16:0] mu_inv;
    } mlem_cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } mlem_qstat_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } mlem_div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } mlem_div_rsp_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LN_M1,
        ST_LN_M2,
        ST_LN_M3,
        ST_LN_M4,
        ST_LN_ACC,
        ST_LN_SUM,
        ST_BP_RD,
        ST_BP_ADDR,
        ST_BP_READ,
        ST_BP_DIV,
        ST_BP_WAIT,
        ST_BP_WR,
        ST_UP_M1,
        ST_UP_M2,
        ST_UP_M3,
        ST_UP_CHK,
        ST_UP_WAIT,
        ST_EMIT
    } mlem_state_t;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        return (|v[63:32]) ? MAX32 : v[31:0];
    endfunction

    function automatic logic [47:0] sat48(input logic [48:0] v);
        return v[48] ? 48'hFFFF_FFFF_FFFF : v[47:0];
    endfunction

endpackage

@@ hw/rtl/mlem_front.sv @@
// mlem_front: configuration registers, input handshake and item classification.
// Depends on mlem_pkg; feeds mlem_queue.
module mlem_front
    import mlem_pkg::*;
#(
    parameter int VOXELS = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mlem_in_t              s_data,
    input  logic                  init_done,
    input  mlem_qstat_t           q_stat,
    output logic                  push,
    output mlem_cmd_t             cmd,
    output mlem_cfg_t             cfg
);
    localparam logic [16:0] VOX_LIMIT = 17'(VOXELS);

    logic [2:0]  mode_reg, mode_next;
    logic [16:0] mu_reg, mu_next;
    logic [16:0] mu_eff;

    always_comb begin
        mode_next = mode_reg;
        mu_next   = mu_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_BLEND_MODE: mode_next = cfg_wdata[2:0];
                REG_BLEND_MU:   mu_next   = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NONE;
            mu_reg   <= '0;
        end else begin
            mode_reg <= mode_next;
            mu_reg   <= mu_next;
        end
    end

    // clamp mu to one
    assign mu_eff     = (mu_reg > ONE_Q16) ? ONE_Q16 : mu_reg;
    assign cfg.mode   = mode_reg;
    assign cfg.mu     = mu_eff;
    assign cfg.mu_inv = ONE_Q16 - mu_eff;

    assign s_ready = init_done && !q_stat.full;

    always_comb begin
        cmd.voxel_index  = s_data.voxel_index;
        cmd.in_range     = ({5'b0, s_data.voxel_index} < VOX_LIMIT);
        cmd.sample_value = s_data.sample_value;
        cmd.beam_value   = s_data.beam_value;
        cmd.line_last    = s_data.line_last;
        case (s_data.kind)
            KIND_LINE:   cmd.op = OP_LINE;
            KIND_UPDATE: cmd.op = OP_UPDATE;
            default:     cmd.op = OP_LOAD;
        endcase
        // drop the unused kind here
        push = s_valid && s_ready && (s_data.kind inside {KIND_LOAD, KIND_LINE, KIND_UPDATE});
    end

endmodule

@@ hw/rtl/mlem_queue.sv @@
// mlem_queue: short command queue between the front and back parts.
// Depends on mlem_pkg.
module mlem_queue
    import mlem_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  mlem_cmd_t   push_data,
    input  logic        pop,
    output mlem_cmd_t   head,
    output mlem_qstat_t stat
);
    mlem_cmd_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign stat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/mlem_divider.sv @@
// mlem_divider: 64-bit restoring divider, one quotient bit per cycle.
// Depends on mlem_pkg; shared by back projection and voxel update.
module mlem_divider
    import mlem_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  mlem_div_req_t req,
    output mlem_div_rsp_t rsp
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  step_reg, step_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] dvs_reg, dvs_next;
    logic [64:0] trial;
    logic        ge;

    assign trial = {rem_reg, quo_reg[63]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next  = ge ? 64'(trial - {1'b0, dvs_reg}) : trial[63:0];
            quo_next  = {quo_reg[62:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == 6'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ hw/rtl/mlem_back.sv @@
// mlem_back: sequencer, voxel memories, shared multiplier and result register.
// Depends on mlem_pkg; takes commands from mlem_queue and uses mlem_divider.
module mlem_back
    import mlem_pkg::*;
#(
    parameter int VOXELS = 4096
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  mlem_cfg_t     cfg,
    input  mlem_cmd_t     q_head,
    input  mlem_qstat_t   q_stat,
    output logic          q_pop,
    output logic          init_done,
    output mlem_div_req_t div_req,
    input  mlem_div_rsp_t div_rsp,
    output logic          m_valid,
    input  logic          m_ready,
    output mlem_out_t     m_data
);
    localparam int ADDR_W = $clog2(VOXELS);
    localparam int CNT_W  = ADDR_W + 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(VOXELS - 1);

    function automatic logic [ADDR_W-1:0] to_addr(input logic [11:0] idx);
        logic [16:0] ext;
        ext = {5'b0, idx};
        return ext[ADDR_W-1:0];
    endfunction

    // memories and their registered read data
    logic [31:0]       image_mem [VOXELS];
    logic [32:0]       lb_mem    [VOXELS];
    logic [47:0]       bp_mem    [VOXELS];
    logic [ADDR_W-1:0] touch_mem [VOXELS];
    logic [31:0]       image_rd;
    logic [32:0]       lb_rd;
    logic [47:0]       bp_rd;
    logic [ADDR_W-1:0] touch_rd;

    logic              img_we, lb_we, bp_we, tl_we;
    logic [ADDR_W-1:0] img_waddr, lb_waddr, bp_waddr, tl_waddr, raddr, tl_raddr;
    logic [31:0]       img_wdata;
    logic [32:0]       lb_wdata;
    logic [47:0]       bp_wdata;
    logic [ADDR_W-1:0] tl_wdata;

    mlem_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0] cur_addr_reg, cur_addr_next;
    mlem_cmd_t         cmd_reg, cmd_next;
    logic [63:0]       tmp_reg, tmp_next;
    logic              hinz_reg, hinz_next;
    logic [31:0]       e_reg, e_next;
    logic [47:0]       bp_hold_reg, bp_hold_next;
    logic [63:0]       fsum_reg, fsum_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    mlem_out_t         res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    mlem_out_t         out_data_reg, out_data_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod_reg, prod_next;
    logic [31:0] img_val;
    logic [32:0] f33;
    logic [64:0] sum65;
    logic [63:0] fsum_new;
    logic [64:0] lo65;
    logic [63:0] wide;

    assign img_val   = cmd_reg.in_range ? image_rd : '0;
    assign prod_next = 64'(mul_a) * 64'(mul_b);
    assign tl_raddr  = k_reg[ADDR_W-1:0];
    assign init_done = (state_reg != ST_CLEAR);

    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        cur_addr_next  = cur_addr_reg;
        cmd_next       = cmd_reg;
        tmp_next       = tmp_reg;
        hinz_next      = hinz_reg;
        e_next         = e_reg;
        bp_hold_next   = bp_hold_reg;
        fsum_next      = fsum_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_ready;
        q_pop          = 1'b0;
        img_we         = 1'b0;
        img_waddr      = cur_addr_reg;
        img_wdata      = cmd_reg.sample_value;
        lb_we          = 1'b0;
        lb_waddr       = cur_addr_reg;
        lb_wdata       = '0;
        bp_we          = 1'b0;
        bp_waddr       = cur_addr_reg;
        bp_wdata       = '0;
        tl_we          = 1'b0;
        tl_waddr       = cnt_reg[ADDR_W-1:0];
        raddr          = cur_addr_reg;
        mul_a          = '0;
        mul_b          = '0;
        div_req.start    = 1'b0;
        div_req.dividend = tmp_reg;
        div_req.divisor  = {32'b0, cmd_reg.sample_value};
        f33      = 33'({16'b0, cfg.mu_inv}) + 33'(prod_reg[47:16]);
        sum65    = {1'b0, fsum_reg} + 65'(prod_reg[63:16]);
        fsum_new = sum65[64] ? '1 : sum65[63:0];
        lo65     = {1'b0, tmp_reg} + {1'b0, prod_reg[31:0], 32'b0};
        wide     = '0;

        case (state_reg)
            ST_CLEAR: begin
                // sweep valid bits and back projection to zero
                lb_we         = 1'b1;
                lb_waddr      = clr_addr_reg;
                bp_we         = 1'b1;
                bp_waddr      = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                raddr = to_addr(q_head.voxel_index);
                if (!q_stat.empty) begin
                    q_pop         = 1'b1;
                    cmd_next      = q_head;
                    cur_addr_next = raddr;
                    case (q_head.op)
                        OP_LOAD: begin
                            img_we    = q_head.in_range;
                            img_waddr = raddr;
                            img_wdata = q_head.sample_value;
                        end
                        OP_LINE:   state_next = ST_LN_M1;
                        OP_UPDATE: state_next = ST_UP_M1;
                        default: ;
                    endcase
                end
            end
            ST_LN_M1: begin
                case (cfg.mode)
                    MODE_MUL: begin
                        mul_a = cmd_reg.sample_value;
                        mul_b = cmd_reg.beam_value;
                    end
                    MODE_MIX: begin
                        mul_a = {15'b0, cfg.mu};
                        mul_b = cmd_reg.beam_value;
                    end
                    MODE_FORCE: begin
                        mul_a = {15'b0, cfg.mu_inv};
                        mul_b = cmd_reg.sample_value;
                    end
                    MODE_INV: begin
                        mul_a = {15'b0, cfg.mu};
                        mul_b = cmd_reg.sample_value;
                    end
                    default: ;
                endcase
                state_next = ST_LN_M2;
            end
            ST_LN_M2: begin
                tmp_next   = (cfg.mode == MODE_MIX) ? 64'(f33) : prod_reg;
                state_next = ST_LN_M3;
            end
            ST_LN_M3: begin
                case (cfg.mode)
                    MODE_MIX: begin
                        mul_a = cmd_reg.sample_value;
                        mul_b = tmp_reg[31:0];
                    end
                    MODE_FORCE: begin
                        mul_a = {15'b0, cfg.mu};
                        mul_b = cmd_reg.beam_value;
                    end
                    MODE_INV: begin
                        mul_a = {15'b0, cfg.mu_inv};
                        mul_b = cmd_reg.beam_value;
                    end
                    default: ;
                endcase
                state_next = ST_LN_M4;
            end
            ST_LN_M4: begin
                case (cfg.mode)
                    MODE_MUL: e_next = sat32({16'b0, tmp_reg[63:16]});
                    MODE_MIX: begin
                        wide = {16'b0, prod_reg[63:16]}
                             + (tmp_reg[32] ? {16'b0, cmd_reg.sample_value, 16'b0} : 64'b0);
                        e_next = sat32(wide);
                    end
                    MODE_FORCE, MODE_INV: begin
                        wide   = tmp_reg + prod_reg;
                        e_next = sat32({16'b0, wide[63:16]});
                    end
                    MODE_BEAM: e_next = cmd_reg.beam_value;
                    default:   e_next = cmd_reg.sample_value;
                endcase
                state_next = ST_LN_ACC;
            end
            ST_LN_ACC: begin
                mul_a = e_reg;
                mul_b = img_val;
                if (cmd_reg.in_range) begin
                    lb_we    = 1'b1;
                    lb_wdata = {1'b1, lb_rd[32] ? sat32(64'(lb_rd[31:0]) + 64'(e_reg)) : e_reg};
                    if (!lb_rd[32]) begin
                        // first touch in this line: note it for the pass
                        tl_we    = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                state_next = ST_LN_SUM;
            end
            ST_LN_SUM: begin
                fsum_next = fsum_new;
                if (cmd_reg.line_last) begin
                    res_next.result_value  = sat32(fsum_new);
                    res_next.is_projection = 1'b1;
                    res_next.line_skipped  = (fsum_new == '0);
                    res_next.saturated     = |fsum_new[63:32];
                    k_next                 = '0;
                    state_next             = (cnt_reg != '0) ? ST_BP_RD : ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_BP_RD:   state_next = ST_BP_ADDR;
            ST_BP_ADDR: begin
                cur_addr_next = touch_rd;
                state_next    = ST_BP_READ;
            end
            ST_BP_READ: state_next = ST_BP_DIV;
            ST_BP_DIV: begin
                if (fsum_reg != '0) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {16'b0, lb_rd[31:0], 16'b0};
                    div_req.divisor  = fsum_reg;
                    state_next       = ST_BP_WAIT;
                end else begin
                    state_next = ST_BP_WR;
                end
            end
            ST_BP_WAIT: begin
                if (div_rsp.done) begin
                    state_next = ST_BP_WR;
                end
            end
            ST_BP_WR: begin
                lb_we    = 1'b1;
                lb_wdata = {1'b0, lb_rd[31:0]};
                if (fsum_reg != '0) begin
                    bp_we    = 1'b1;
                    bp_wdata = sat48(49'(bp_rd) + 49'(div_rsp.quotient[47:0]));
                end
                k_next = k_reg + 1'b1;
                if (k_reg + 1'b1 == cnt_reg) begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_BP_RD;
                end
            end
            ST_UP_M1: begin
                bp_hold_next = cmd_reg.in_range ? bp_rd : '0;
                mul_a        = img_val;
                mul_b        = bp_rd[31:0];
                bp_we        = cmd_reg.in_range;
                state_next   = ST_UP_M2;
            end
            ST_UP_M2: begin
                tmp_next   = prod_reg;
                mul_a      = img_val;
                mul_b      = {16'b0, bp_hold_reg[47:32]};
                state_next = ST_UP_M3;
            end
            ST_UP_M3: begin
                tmp_next   = lo65[63:0];
                hinz_next  = lo65[64] || (|prod_reg[47:32]);
                state_next = ST_UP_CHK;
            end
            ST_UP_CHK: begin
                res_next.is_projection = 1'b0;
                res_next.line_skipped  = 1'b0;
                if (cmd_reg.sample_value == '0 || hinz_reg
                    || tmp_reg[63:32] >= cmd_reg.sample_value) begin
                    res_next.result_value = MAX32;
                    res_next.saturated    = 1'b1;
                    state_next            = ST_EMIT;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = ST_UP_WAIT;
                end
            end
            ST_UP_WAIT: begin
                if (div_rsp.done) begin
                    res_next.result_value = div_rsp.quotient[31:0];
                    res_next.saturated    = 1'b0;
                    state_next            = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_ready) begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    if (res_reg.is_projection) begin
                        fsum_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // touch list entry is the current voxel address
    assign tl_wdata = cur_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            fsum_reg      <= '0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            fsum_reg      <= fsum_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_addr_reg <= cur_addr_next;
        cmd_reg      <= cmd_next;
        tmp_reg      <= tmp_next;
        hinz_reg     <= hinz_next;
        e_reg        <= e_next;
        bp_hold_reg  <= bp_hold_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        prod_reg     <= prod_next;
    end

    always_ff @(posedge aclk) begin
        if (img_we) begin
            image_mem[img_waddr] <= img_wdata;
        end
        image_rd <= image_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (lb_we) begin
            lb_mem[lb_waddr] <= lb_wdata;
        end
        lb_rd <= lb_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (bp_we) begin
            bp_mem[bp_waddr] <= bp_wdata;
        end
        bp_rd <= bp_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (tl_we) begin
            touch_mem[tl_waddr] <= tl_wdata;
        end
        touch_rd <= touch_mem[tl_raddr];
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

@@ hw/rtl/mlem_projection_update.sv @@
// MLEM projection update: a load is stored when the back part pops it from the queue; a line
// element holds the back part through its multiply, blend, accumulate and sum states; the last
// one adds a back projection pass per distinct voxel (no division on a zero projection) before
// sending; an update's result comes from the 64-step divider unless it clips. One request runs
// at a time. aresetn is synchronous, active low; a clear pass follows, accepting no request.
// Depends on mlem_pkg, mlem_front, mlem_queue, mlem_divider and mlem_back.
module mlem_projection_update
    import mlem_pkg::*;
#(
    parameter int VOXELS = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mlem_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mlem_out_t             m_data
);
    mlem_cfg_t     cfg;
    mlem_cmd_t     push_cmd;
    mlem_cmd_t     q_head;
    mlem_qstat_t   q_stat;
    mlem_div_req_t div_req;
    mlem_div_rsp_t div_rsp;
    logic          push;
    logic          q_pop;
    logic          init_done;

    // front: registers, handshake, classification; unused kinds are dropped here
    mlem_front #(
        .VOXELS (VOXELS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .init_done (init_done),
        .q_stat    (q_stat),
        .push      (push),
        .cmd       (push_cmd),
        .cfg       (cfg)
    );

    // hold classified requests while the back part is busy
    mlem_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_cmd),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    // shared divider for back projection and voxel update
    mlem_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // back: memories, blend, accumulate, back projection and result register
    mlem_back #(
        .VOXELS (VOXELS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .q_head    (q_head),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .init_done (init_done),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // never push into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("request pushed into full queue");

    // never pop an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("request popped from empty queue");

    // a skipped line reports a zero projection
    a_skip_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.line_skipped |-> m_data.is_projection && m_data.result_value == '0)
        else $error("skipped line with nonzero projection");

    // a clipped projection reads all ones
    a_proj_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_projection && m_data.saturated |-> m_data.result_value == MAX32)
        else $error("saturated projection not clipped");

endmodule

@@ verif/mlem_projection_update_test.sv @@
// Self-checking testbench for mlem_projection_update: random and directed requests
// with a built-in Q16.16 predictor of image load, line blend/projection and update.
// Depends on mlem_pkg and the mlem_projection_update RTL.
`timescale 1ns / 100ps

module mlem_projection_update_test;
    import mlem_pkg::*;

    localparam int NVOX      = 4096;
    localparam int STALL_MAX = 20000;   // cycles with no handshake before giving up
    localparam int SETTLE    = 300;     // quiet cycles before a register write or the end
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    mlem_in_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    mlem_out_t             m_data;

    mlem_projection_update #(.VOXELS(NVOX)) dut (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_wdata,
        .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // ---------------------------------------------------------------------
    // Predictor state: our own copy of the block's stores and registers
    // ---------------------------------------------------------------------
    logic [31:0] image_mem   [NVOX];
    logic [47:0] bproj_mem   [NVOX];
    logic [31:0] line_mem    [NVOX];
    bit          line_used   [NVOX];
    int          line_voxels [$];
    logic [63:0] fwd_sum     = '0;
    logic [2:0]  cur_mode    = MODE_NONE;
    logic [16:0] cur_mu      = '0;

    mlem_out_t   expected_results [$];
    mlem_in_t    pending_requests [$];

    bit          image_loaded [NVOX];   // generator side: voxels safe to read
    logic [11:0] loaded_voxels [$];

    int          mismatches = 0;
    int          results_seen = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    initial begin
        for (int i = 0; i < NVOX; i++) begin
            bproj_mem[i]    = '0;
            line_used[i]    = 1'b0;
            image_loaded[i] = 1'b0;
        end
    end

    function automatic logic [31:0] clip32(input logic [127:0] v);
        return (|v[127:32]) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // Blend one line element with its beam prior under the current mode.
    function automatic logic [31:0] blend_element(input logic [31:0] s, input logic [31:0] b);
        logic [127:0] mu;
        logic [127:0] f;
        mu = (cur_mu > ONE_Q16) ? 128'(ONE_Q16) : 128'(cur_mu);
        case (cur_mode)
            MODE_MUL: begin
                return clip32((128'(s) * 128'(b)) >> 16);
            end
            MODE_MIX: begin
                f = 128'(ONE_Q16) - mu + ((mu * 128'(b)) >> 16);
                return clip32((128'(s) * f) >> 16);
            end
            MODE_FORCE: begin
                return clip32(((128'(ONE_Q16) - mu) * 128'(s) + mu * 128'(b)) >> 16);
            end
            MODE_INV: begin
                return clip32((mu * 128'(s) + (128'(ONE_Q16) - mu) * 128'(b)) >> 16);
            end
            MODE_BEAM: begin
                return b;
            end
            default: begin
                return s;
            end
        endcase
    endfunction

    // Advance the predictor by one accepted request; queue the result it causes.
    task automatic apply_request(input mlem_in_t r);
        logic [31:0]  e;
        logic [63:0]  p;
        logic [64:0]  acc;
        logic [63:0]  f;
        logic [63:0]  inc;
        logic [64:0]  nb;
        logic [127:0] prod;
        logic [127:0] lim;
        mlem_out_t    o;
        case (r.kind)
            KIND_LOAD: begin
                image_mem[r.voxel_index] = r.sample_value;
            end
            KIND_LINE: begin
                e = blend_element(r.sample_value, r.beam_value);
                p = (64'(e) * 64'(image_mem[r.voxel_index])) >> 16;
                if (line_used[r.voxel_index]) begin
                    line_mem[r.voxel_index] = clip32(128'(line_mem[r.voxel_index]) + 128'(e));
                end else begin
                    line_mem[r.voxel_index] = e;
                    line_used[r.voxel_index] = 1'b1;
                    line_voxels.insert(line_voxels.size(), int'(r.voxel_index));
                end
                acc = 65'(fwd_sum) + 65'(p);
                fwd_sum = acc[64] ? '1 : acc[63:0];
                if (r.line_last) begin
                    f = fwd_sum;
                    foreach (line_voxels[k]) begin
                        if (f != 0) begin
                            inc = ({32'b0, line_mem[line_voxels[k]]} << 16) / f;
                            nb = 65'(bproj_mem[line_voxels[k]]) + 65'(inc);
                            bproj_mem[line_voxels[k]] = (nb > 65'hFFFF_FFFF_FFFF) ?
                                48'hFFFF_FFFF_FFFF : nb[47:0];
                        end
                        line_used[line_voxels[k]] = 1'b0;
                    end
                    line_voxels.delete();
                    fwd_sum = '0;
                    o.result_value  = clip32(128'(f));
                    o.is_projection = 1'b1;
                    o.line_skipped  = (f == 0);
                    o.saturated     = (f > 64'hFFFF_FFFF);
                    expected_results.insert(expected_results.size(), o);
                end
            end
            KIND_UPDATE: begin
                prod = 128'(image_mem[r.voxel_index]) * 128'(bproj_mem[r.voxel_index]);
                lim  = 128'(r.sample_value) << 32;
                bproj_mem[r.voxel_index] = '0;
                o.is_projection = 1'b0;
                o.line_skipped  = 1'b0;
                if (r.sample_value == 0 || prod >= lim) begin
                    o.result_value = 32'hFFFF_FFFF;
                    o.saturated    = 1'b1;
                end else begin
                    o.result_value = 32'(prod / 128'(r.sample_value));
                    o.saturated    = 1'b0;
                end
                expected_results.insert(expected_results.size(), o);
            end
            default: ;   // unused kind: dropped by the block
        endcase
    endtask

    // ---------------------------------------------------------------------
    // Request driver: hold valid and payload until accepted, idle at random
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_request(s_data);
            end
            if (!s_valid || s_ready) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_requests.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result side: random back-pressure plus one long hold-off to fill the block
    // ---------------------------------------------------------------------
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_done && results_seen >= 30) begin
            // stall for a long stretch while the driver keeps offering requests
            hold_done <= 1'b1;
            hold_left <= 1500;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        mlem_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value=%h proj=%b skip=%b sat=%b",
                             m_data.result_value, m_data.is_projection,
                             m_data.line_skipped, m_data.saturated);
            end else begin
                want = expected_results.pop_front();
                if (m_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: value exp %h got %h, proj exp %b got %b, %s%b %s%b",
                                 want.result_value, m_data.result_value,
                                 want.is_projection, m_data.is_projection,
                                 "skip exp/got ", {want.line_skipped, m_data.line_skipped},
                                 "sat exp/got ", {want.saturated, m_data.saturated});
                end
            end
        end
    end

    // Watchdog: too long without any handshake on either channel.
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_MAX) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    task automatic push_request(input logic [1:0] kind, input logic [11:0] idx,
                                input logic [31:0] sv, input logic [31:0] bv,
                                input logic last);
        mlem_in_t r;
        r.kind = kind;
        r.voxel_index = idx;
        r.sample_value = sv;
        r.beam_value = bv;
        r.line_last = last;
        pending_requests.insert(pending_requests.size(), r);
    endtask

    function automatic logic [31:0] pick_q16();
        case ($urandom_range(7))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom;
            4:       return 32'h0001_0000 + $urandom_range(0, 4095) - 2048;
            default: return $urandom_range(0, 32'h0004_0000);
        endcase
    endfunction

    task automatic load_voxel(input logic [11:0] idx, input logic [31:0] val);
        push_request(KIND_LOAD, idx, val, $urandom, 1'($urandom_range(1)));
        if (!image_loaded[idx]) begin
            image_loaded[idx] = 1'b1;
            loaded_voxels.insert(loaded_voxels.size(), idx);
        end
    endtask

    function automatic logic [11:0] any_loaded();
        return loaded_voxels[$urandom_range(loaded_voxels.size() - 1)];
    endfunction

    task automatic send_line(input int len);
        logic [11:0] idx;
        for (int i = 0; i < len; i++) begin
            // revisit the previous voxel now and then to cover accumulation in the buffer
            if (i == 0 || $urandom_range(5) != 0) idx = any_loaded();
            push_request(KIND_LINE, idx, pick_q16(), pick_q16(), i == len - 1);
        end
    endtask

    // Drain the block completely before touching its registers.
    task automatic settle();
        while (pending_requests.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == REG_BLEND_MODE) cur_mode = val[2:0];
        else cur_mu = val;
    endtask

    task automatic random_phase(input int n);
        int sel;
        int cnt;
        cnt = 0;
        while (cnt < n) begin
            sel = $urandom_range(99);
            if (sel < 12) begin
                load_voxel(12'($urandom), pick_q16());
                cnt++;
            end else if (sel < 62) begin
                sel = ($urandom_range(9) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 4);
                send_line(sel);
                cnt += sel;
            end else if (sel < 97) begin
                push_request(KIND_UPDATE, any_loaded(),
                             ($urandom_range(9) == 0) ? 32'h0 : pick_q16(), $urandom,
                             1'($urandom_range(1)));
                cnt++;
            end else begin
                push_request(KIND_UNUSED, 12'($urandom), $urandom, $urandom,
                             1'($urandom_range(1)));
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        logic [16:0] mus [4];
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        write_reg(REG_BLEND_MODE, CFG_DATA_W'(MODE_NONE));
        write_reg(REG_BLEND_MU, 17'd0);

        // directed: field extremes, zero projection, saturation, repeated voxel
        send_idle_pct = 24;
        recv_idle_pct = 71;
        load_voxel(12'd0, 32'h0);
        load_voxel(12'hFFF, 32'hFFFF_FFFF);
        load_voxel(12'h555, 32'h0001_0000);
        load_voxel(12'hAAA, 32'h0002_8000);
        push_request(KIND_LINE, 12'd0, 32'hFFFF_FFFF, 32'h0, 1'b1);          // skipped line
        push_request(KIND_LINE, 12'h555, 32'h0, 32'hFFFF_FFFF, 1'b1);        // zero element
        push_request(KIND_LINE, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        push_request(KIND_LINE, 12'hFFF, 32'hFFFF_FFFF, 32'h0, 1'b1);        // saturating sum
        push_request(KIND_LINE, 12'h555, 32'h0001_0000, 32'h1, 1'b0);
        push_request(KIND_LINE, 12'h555, 32'h0003_0000, 32'h2, 1'b0);        // same voxel again
        push_request(KIND_LINE, 12'hAAA, 32'h0000_8000, 32'h3, 1'b1);
        push_request(KIND_UNUSED, 12'h123, 32'hDEAD_BEEF, 32'h1234_5678, 1'b1);
        push_request(KIND_UPDATE, 12'h555, 32'h0, 32'h0, 1'b0);              // zero sensitivity
        push_request(KIND_UPDATE, 12'hAAA, 32'h1, 32'hFFFF_FFFF, 1'b1);      // smallest nonzero sensitivity
        push_request(KIND_UPDATE, 12'hFFF, 32'hFFFF_FFFF, 32'h0, 1'b0);
        push_request(KIND_UPDATE, 12'h555, 32'h0001_0000, 32'h0, 1'b0);      // already cleared
        push_request(KIND_UPDATE, 12'd0, 32'h0001_0000, 32'h0, 1'b0);
        for (int i = 0; i < 6; i++) load_voxel(12'($urandom), pick_q16());
        settle();

        // random: sweep every mode code with several mu values, extremes included
        mus = '{17'd0, 17'h10000, 17'h1FFFF, 17'h0};
        for (int m = 0; m < 8; m++) begin
            if (m < 3) begin
                send_idle_pct = 24;
                recv_idle_pct = 71;
            end else if (m < 6) begin
                send_idle_pct = 71;
                recv_idle_pct = 24;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            mus[3] = 17'($urandom_range(17'h1FFFF));
            write_reg(REG_BLEND_MODE, CFG_DATA_W'(m));
            write_reg(REG_BLEND_MU, mus[m % 4]);
            random_phase(24);
            settle();
            write_reg(REG_BLEND_MU, mus[(m + 1) % 4]);
            random_phase(24);
            settle();
        end

        if (expected_results.size() != 0) mismatches += expected_results.size();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
